/* rtl/core/gel_pkg.sv */
`default_nettype none

package gel_pkg;

    // Cross geometry
    localparam int FOUNDERS = 8;
    localparam int GENOS    = (FOUNDERS * (FOUNDERS + 1)) / 2;
    localparam int LOG_W    = 32;

    localparam int FIDX_W = $clog2(FOUNDERS);
    localparam int GENO_W = 6;
    localparam int OBS_W  = 3;
    localparam int CALL_W = 2;

    localparam logic [GENO_W-1:0] GENO_PAIR_LAST  = GENO_W'(GENOS);
    localparam logic [GENO_W-1:0] GENO_MALE_FIRST = GENO_W'(GENOS + 1);
    localparam logic [GENO_W-1:0] GENO_MALE_LAST  = GENO_W'(GENOS + FOUNDERS);

    // Founder call codes
    localparam logic [CALL_W-1:0] CALL_MISSING = 2'd0;
    localparam logic [CALL_W-1:0] CALL_A       = 2'd1;
    localparam logic [CALL_W-1:0] CALL_HET     = 2'd2;
    localparam logic [CALL_W-1:0] CALL_B       = 2'd3;

    // Observed call codes
    localparam logic [OBS_W-1:0] OBS_MISSING = 3'd0;
    localparam logic [OBS_W-1:0] OBS_A       = 3'd1;
    localparam logic [OBS_W-1:0] OBS_H       = 3'd2;
    localparam logic [OBS_W-1:0] OBS_B       = 3'd3;
    localparam logic [OBS_W-1:0] OBS_NOT_B   = 3'd4;
    localparam logic [OBS_W-1:0] OBS_NOT_A   = 3'd5;

    // Register map indexes
    localparam logic [1:0] REG_LOG_KEEP       = 2'd0;
    localparam logic [1:0] REG_LOG_ERROR      = 2'd1;
    localparam logic [1:0] REG_LOG_HALF_ERROR = 2'd2;
    localparam logic [1:0] REG_LOG_KEEP_HALF  = 2'd3;

    typedef enum logic [2:0] {
        TERM_ZERO      = 3'd0,
        TERM_KEEP      = 3'd1,
        TERM_ERROR     = 3'd2,
        TERM_HALF      = 3'd3,
        TERM_KEEP_HALF = 3'd4
    } term_t;

    typedef enum logic [1:0] {
        CLS_AA = 2'd0,
        CLS_AB = 2'd1,
        CLS_BB = 2'd2
    } cls_t;

    typedef struct packed {
        logic [OBS_W-1:0]                 observed_call;
        logic [GENO_W-1:0]                hidden_genotype;
        logic                             on_x;
        logic                             female;
        logic [FOUNDERS-1:0][CALL_W-1:0]  founder_call;
    } item_t;

    typedef struct packed {
        term_t term;
        logic  bad;
    } sel_t;

    typedef struct packed {
        logic [FIDX_W-1:0] lo;
        logic [FIDX_W-1:0] hi;
    } pair_t;

    // Het founder calls carry no allele information
    function automatic logic [CALL_W-1:0] clean_call(logic [CALL_W-1:0] c);
        return (c == CALL_HET) ? CALL_MISSING : c;
    endfunction

    // Pair code b*(b-1)/2 + a -> zero-based founder indexes
    function automatic pair_t pair_decode(logic [GENO_W-1:0] g);
        pair_t             p;
        logic [GENO_W-1:0] base;
        logic              found;
        p     = '0;
        base  = '0;
        found = 1'b0;
        for (int i = 1; i <= FOUNDERS; i++)
        begin
            if (!found && (g <= base + GENO_W'(i)))
            begin
                p.hi  = FIDX_W'(i - 1);
                p.lo  = FIDX_W'(g - base - GENO_W'(1));
                found = 1'b1;
            end
            base = base + GENO_W'(i);
        end
        return p;
    endfunction

    // One founder allele observed
    function automatic term_t tab_one(logic is_a, logic [OBS_W-1:0] obs);
        term_t t;
        unique case (obs)
            OBS_A, OBS_NOT_B: t = is_a ? TERM_KEEP : TERM_ERROR;
            OBS_B, OBS_NOT_A: t = is_a ? TERM_ERROR : TERM_KEEP;
            default:          t = TERM_ZERO;
        endcase
        return t;
    endfunction

    // Two founder alleles observed
    function automatic term_t tab_two(cls_t cls, logic [OBS_W-1:0] obs);
        term_t t;
        t = TERM_ZERO;
        unique case (cls)
            CLS_AA:
            begin
                unique case (obs)
                    OBS_A:     t = TERM_KEEP;
                    OBS_H:     t = TERM_HALF;
                    OBS_B:     t = TERM_HALF;
                    OBS_NOT_B: t = TERM_KEEP_HALF;
                    OBS_NOT_A: t = TERM_ERROR;
                    default:   t = TERM_ZERO;
                endcase
            end
            CLS_AB:
            begin
                unique case (obs)
                    OBS_A:     t = TERM_HALF;
                    OBS_H:     t = TERM_KEEP;
                    OBS_B:     t = TERM_HALF;
                    OBS_NOT_B: t = TERM_KEEP_HALF;
                    OBS_NOT_A: t = TERM_KEEP_HALF;
                    default:   t = TERM_ZERO;
                endcase
            end
            CLS_BB:
            begin
                unique case (obs)
                    OBS_A:     t = TERM_HALF;
                    OBS_H:     t = TERM_HALF;
                    OBS_B:     t = TERM_KEEP;
                    OBS_NOT_B: t = TERM_ERROR;
                    OBS_NOT_A: t = TERM_KEEP_HALF;
                    default:   t = TERM_ZERO;
                endcase
            end
            default: t = TERM_ZERO;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/gel_if.sv */
`default_nettype none

// Input word channel
interface gel_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] observed_call;
    logic [5:0] hidden_genotype;
    logic       on_x;
    logic       female;
    logic [1:0] founder_1_call;
    logic [1:0] founder_2_call;
    logic [1:0] founder_3_call;
    logic [1:0] founder_4_call;
    logic [1:0] founder_5_call;
    logic [1:0] founder_6_call;
    logic [1:0] founder_7_call;
    logic [1:0] founder_8_call;

    modport source (
        output valid, observed_call, hidden_genotype, on_x, female,
               founder_1_call, founder_2_call, founder_3_call, founder_4_call,
               founder_5_call, founder_6_call, founder_7_call, founder_8_call,
        input  ready
    );

    modport sink (
        input  valid, observed_call, hidden_genotype, on_x, female,
               founder_1_call, founder_2_call, founder_3_call, founder_4_call,
               founder_5_call, founder_6_call, founder_7_call, founder_8_call,
        output ready
    );
endinterface

// Result word channel
interface gel_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] loglik;
    logic [2:0]         term_code;
    logic               bad_genotype;

    modport source (
        output valid, loglik, term_code, bad_genotype,
        input  ready
    );

    modport sink (
        input  valid, loglik, term_code, bad_genotype,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/genotype_emission_loglik.sv */
`default_nettype none

// Channel   Dir  Handshake      Payload
// item      in   valid/ready    observed_call, hidden_genotype, on_x, female,
//                               founder_1_call .. founder_8_call
// result    out  valid/ready    loglik, term_code, bad_genotype
// apb       in   psel/penable   paddr, pwdata (write), prdata (read)
//
// Two register stages: input word register, then result register. One word per
// cycle is sustained while result.ready is high; a stalled result holds the flow.
// Term selection between the stages is a small lookup and a mux over the four
// log registers and zero.
// A stalled result holds a full input stage; item.ready drops only when both
// stages are full and the result is stalled.
// rst_n clears the valid flags and the four log registers to zero.
module genotype_emission_loglik
    import gel_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    gel_item_if.sink           item,
    gel_result_if.source       result,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [LOG_W-1:0] log_keep_reg;
    logic [LOG_W-1:0] log_error_reg;
    logic [LOG_W-1:0] log_half_error_reg;
    logic [LOG_W-1:0] log_keep_half_reg;

    logic             s1_valid_reg;
    item_t            s1_item_reg;
    item_t            s1_item_next;
    logic             out_valid_reg;
    logic [LOG_W-1:0] loglik_reg;
    logic [LOG_W-1:0] loglik_next;
    term_t            term_reg;
    logic             bad_reg;

    sel_t             sel;
    logic             out_adv;
    logic             s1_adv;
    logic             cfg_wr;
    logic [1:0]       reg_idx;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_keep_reg       <= '0;
            log_error_reg      <= '0;
            log_half_error_reg <= '0;
            log_keep_half_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_LOG_KEEP:       log_keep_reg       <= pwdata;
                REG_LOG_ERROR:      log_error_reg      <= pwdata;
                REG_LOG_HALF_ERROR: log_half_error_reg <= pwdata;
                REG_LOG_KEEP_HALF:  log_keep_half_reg  <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LOG_KEEP:       prdata = log_keep_reg;
            REG_LOG_ERROR:      prdata = log_error_reg;
            REG_LOG_HALF_ERROR: prdata = log_half_error_reg;
            REG_LOG_KEEP_HALF:  prdata = log_keep_half_reg;
            default:            prdata = '0;
        endcase
    end

    // Pipeline flow control
    assign out_adv    = !out_valid_reg || result.ready;
    assign s1_adv     = !s1_valid_reg || out_adv;
    assign item.ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= item.valid;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Input word register
    always_comb
    begin
        s1_item_next.observed_call   = item.observed_call;
        s1_item_next.hidden_genotype = item.hidden_genotype;
        s1_item_next.on_x            = item.on_x;
        s1_item_next.female          = item.female;
        s1_item_next.founder_call[0] = item.founder_1_call;
        s1_item_next.founder_call[1] = item.founder_2_call;
        s1_item_next.founder_call[2] = item.founder_3_call;
        s1_item_next.founder_call[3] = item.founder_4_call;
        s1_item_next.founder_call[4] = item.founder_5_call;
        s1_item_next.founder_call[5] = item.founder_6_call;
        s1_item_next.founder_call[6] = item.founder_7_call;
        s1_item_next.founder_call[7] = item.founder_8_call;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && item.valid)
            s1_item_reg <= s1_item_next;
    end

    // Term selection
    gel_select u_select (
        .item (s1_item_reg),
        .sel  (sel)
    );

    always_comb
    begin
        unique case (sel.term)
            TERM_KEEP:      loglik_next = log_keep_reg;
            TERM_ERROR:     loglik_next = log_error_reg;
            TERM_HALF:      loglik_next = log_half_error_reg;
            TERM_KEEP_HALF: loglik_next = log_keep_half_reg;
            default:        loglik_next = '0;
        endcase
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            loglik_reg <= loglik_next;
            term_reg   <= sel.term;
            bad_reg    <= sel.bad;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.loglik       = loglik_reg;
    assign result.term_code    = term_reg;
    assign result.bad_genotype = bad_reg;

`ifndef SYNTHESIS
    // A flagged genotype never selects a log term
    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && bad_reg |-> term_reg == TERM_ZERO && loglik_reg == '0)
        else $error("bad genotype result carries a nonzero term");

    // Term zero always reads as zero log probability
    a_zero_term: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && term_reg == TERM_ZERO |-> loglik_reg == '0)
        else $error("term zero with nonzero loglik");

    // Both stages full and result stalled: no new word may enter
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !result.ready |-> !item.ready)
        else $error("input accepted while pipeline is full and stalled");

    // A stalled result stays in place
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(loglik_reg))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

/* rtl/core/gel_select.sv */
`default_nettype none

// Term selection for one registered input word
module gel_select
    import gel_pkg::*;
(
    input  item_t item,
    output sel_t  sel
);

    logic [FOUNDERS-1:0][CALL_W-1:0] fc;
    pair_t                           pair;
    logic [CALL_W-1:0]               f1;
    logic [CALL_W-1:0]               f2;
    logic [CALL_W-1:0]               fx;
    logic [FIDX_W-1:0]               male_off;
    logic                            diploid;
    logic                            bad_pair;
    logic                            bad_male;
    term_t                           term_pair;
    term_t                           term_male;
    cls_t                            cls;

    // Clean founder calls
    always_comb
    begin
        for (int i = 0; i < FOUNDERS; i++)
        begin
            fc[i] = clean_call(item.founder_call[i]);
        end
    end

    // Autosome or female X: allele pair lookup
    assign pair     = pair_decode(item.hidden_genotype);
    assign f1       = fc[pair.lo];
    assign f2       = fc[pair.hi];
    assign bad_pair = (item.hidden_genotype == '0) ||
                      (item.hidden_genotype > GENO_PAIR_LAST);

    always_comb
    begin
        if ((f1 == CALL_A) && (f2 == CALL_A))
            cls = CLS_AA;
        else if ((f1 == CALL_B) && (f2 == CALL_B))
            cls = CLS_BB;
        else
            cls = CLS_AB;
    end

    always_comb
    begin
        priority if (item.observed_call == OBS_MISSING ||
                     (f1 == CALL_MISSING && f2 == CALL_MISSING))
            term_pair = TERM_ZERO;
        else if (f1 == CALL_MISSING || f2 == CALL_MISSING)
            // only one of the two is set, so OR picks it
            term_pair = tab_one((f1 | f2) == CALL_A, item.observed_call);
        else
            term_pair = tab_two(cls, item.observed_call);
    end

    // Male X: single founder
    assign male_off  = FIDX_W'(item.hidden_genotype - GENO_MALE_FIRST);
    assign fx        = fc[male_off];
    assign bad_male  = (item.hidden_genotype < GENO_MALE_FIRST) ||
                       (item.hidden_genotype > GENO_MALE_LAST);
    assign term_male = (fx == CALL_MISSING) ? TERM_ZERO
                                            : tab_one(fx == CALL_A, item.observed_call);

    // Final pick; an out-of-range genotype forces zero
    assign diploid = !item.on_x || item.female;

    always_comb
    begin
        sel.bad  = diploid ? bad_pair : bad_male;
        sel.term = sel.bad ? TERM_ZERO : (diploid ? term_pair : term_male);
    end

endmodule

`default_nettype wire
